>>> src/max_heap_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the max-heap priority queue
// Shared concurrent assertion forms, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Checked only while the block is out of reset.
`define MHPQ_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every clock edge, reset included.
`define MHPQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> src/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Types, constants and codes shared by the max-heap priority queue modules.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    // Heap geometry.
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = 10;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [ADDR_W-1:0]       t_addr;
    typedef logic [CNT_W-1:0]        t_count;

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_POP      = 2'd1,
        OP_INCREASE = 2'd2,
        OP_NOP      = 2'd3
    } t_op;

    // Status codes of a result item.
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_FULL       = 3'd2,
        ST_BAD_INDEX  = 3'd3,
        ST_NOT_LARGER = 3'd4
    } t_status;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_INC_CMP,
        S_POP_LAST,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_FINISH
    } t_state;

    // Key store access for one cycle.
    typedef struct packed {
        logic  wr_en;
        t_addr wr_addr;
        t_key  wr_data;
        logic  rd_en;
        t_addr rd_addr;
    } t_ram_req;

    // One finished result item.
    typedef struct packed {
        t_key    top_value;
        t_key    popped_value;
        t_count  entry_count;
        t_status status;
    } t_result;

endpackage

>>> src/mhpq_ram.sv
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

>>> src/mhpq_engine.sv
// ----------------------------------------------------------------------------
// mhpq_engine
// Sequencer that decodes an item and sifts keys through the key store.
// ----------------------------------------------------------------------------
`include "max_heap_priority_queue_macros.svh"

module mhpq_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_operation,
    input  mhpq_pkg::t_key     i_value,
    input  logic [mhpq_pkg::IDX_W-1:0] i_heap_index,
    output mhpq_pkg::t_ram_req o_ram,
    input  mhpq_pkg::t_key     i_rd_key,
    output logic               o_res_valid,
    output mhpq_pkg::t_result  o_res,
    input  logic               i_res_ready
);
    import mhpq_pkg::*;

    t_state   r_state, n_state;
    t_count   r_count, n_count;
    t_key     r_top, n_top;
    t_key     r_key, n_key;
    t_key     r_left_key, n_left_key;
    t_key     r_popped, n_popped;
    t_addr    r_pos, n_pos;
    logic     r_has_r, n_has_r;
    t_status  r_status, n_status;

    t_ram_req w_ram;
    t_op      w_op;
    logic     w_accept;
    logic     w_full;
    logic     w_empty;
    logic     w_bad_index;
    t_count   w_last;
    t_addr    w_parent;
    logic [CNT_W:0] w_left;
    logic [CNT_W:0] w_right;
    logic [CNT_W:0] w_count_x;
    logic     w_up_gt;
    logic     w_left_gt;
    t_key     w_cand;
    logic     w_right_win;

    // Decode and compare terms for the next-state and datapath blocks.
    assign w_op        = t_op'(i_operation);
    assign w_accept    = (r_state == S_IDLE) && i_in_valid;
    assign w_full      = (r_count == t_count'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_bad_index = ({{(CNT_W-IDX_W){1'b0}}, i_heap_index} >= r_count);
    assign w_last      = r_count - t_count'(1);
    assign w_parent    = (r_pos - t_addr'(1)) >> 1;
    assign w_left      = {1'b0, r_pos, 1'b1};
    assign w_right     = w_left + (CNT_W+1)'(1);
    assign w_count_x   = {1'b0, r_count};
    assign w_up_gt     = (r_key > i_rd_key);
    assign w_left_gt   = (r_left_key > r_key);
    assign w_cand      = w_left_gt ? r_left_key : r_key;
    assign w_right_win = r_has_r && (i_rd_key > w_cand);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_op)
                        OP_INSERT:   n_state = w_full ? S_FINISH : S_UP_RD;
                        OP_POP: begin
                            if (w_empty || r_count == t_count'(1)) begin
                                n_state = S_FINISH;
                            end else begin
                                n_state = S_POP_LAST;
                            end
                        end
                        OP_INCREASE: n_state = w_bad_index ? S_FINISH : S_INC_CMP;
                        OP_NOP:      n_state = S_FINISH;
                    endcase
                end
            end
            S_UP_RD:    n_state = (r_pos == '0) ? S_FINISH : S_UP_CMP;
            S_UP_CMP:   n_state = w_up_gt ? S_UP_RD : S_FINISH;
            S_INC_CMP:  n_state = w_up_gt ? S_UP_RD : S_FINISH;
            S_POP_LAST: n_state = S_DN_RDL;
            S_DN_RDL:   n_state = (w_left >= w_count_x) ? S_FINISH : S_DN_RDR;
            S_DN_RDR:   n_state = S_DN_CMP;
            S_DN_CMP:   n_state = (w_right_win || w_left_gt) ? S_DN_RDL : S_FINISH;
            S_FINISH:   n_state = i_res_ready ? S_IDLE : S_FINISH;
            default:    n_state = S_IDLE;
        endcase
    end

    // Outputs and datapath: key store requests and register updates.
    always_comb begin
        w_ram      = '0;
        n_count    = r_count;
        n_key      = r_key;
        n_left_key = r_left_key;
        n_popped   = r_popped;
        n_pos      = r_pos;
        n_has_r    = r_has_r;
        n_status   = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status = ST_OK;
                    n_popped = '0;
                    unique case (w_op)
                        OP_INSERT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_key   = i_value;
                                n_pos   = r_count[ADDR_W-1:0];
                                n_count = r_count + t_count'(1);
                            end
                        end
                        OP_POP: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_popped      = r_top;
                                n_count       = w_last;
                                w_ram.rd_en   = (r_count != t_count'(1));
                                w_ram.rd_addr = w_last[ADDR_W-1:0];
                            end
                        end
                        OP_INCREASE: begin
                            if (w_bad_index) begin
                                n_status = ST_BAD_INDEX;
                            end else begin
                                w_ram.rd_en   = 1'b1;
                                w_ram.rd_addr = t_addr'(i_heap_index);
                                n_key         = i_value;
                                n_pos         = t_addr'(i_heap_index);
                            end
                        end
                        OP_NOP: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_UP_RD: begin
                // At the root the held key lands; otherwise fetch the parent.
                if (r_pos == '0) begin
                    w_ram.wr_en   = 1'b1;
                    w_ram.wr_addr = r_pos;
                    w_ram.wr_data = r_key;
                end else begin
                    w_ram.rd_en   = 1'b1;
                    w_ram.rd_addr = w_parent;
                end
            end
            S_UP_CMP: begin
                // A smaller parent moves down into the hole.
                w_ram.wr_en   = 1'b1;
                w_ram.wr_addr = r_pos;
                if (w_up_gt) begin
                    w_ram.wr_data = i_rd_key;
                    n_pos         = w_parent;
                end else begin
                    w_ram.wr_data = r_key;
                end
            end
            S_INC_CMP: begin
                if (!w_up_gt) begin
                    n_status = ST_NOT_LARGER;
                end
            end
            S_POP_LAST: begin
                // The last entry becomes the key that sifts down from the root.
                n_key = i_rd_key;
                n_pos = '0;
            end
            S_DN_RDL: begin
                if (w_left >= w_count_x) begin
                    w_ram.wr_en   = 1'b1;
                    w_ram.wr_addr = r_pos;
                    w_ram.wr_data = r_key;
                end else begin
                    w_ram.rd_en   = 1'b1;
                    w_ram.rd_addr = w_left[ADDR_W-1:0];
                end
            end
            S_DN_RDR: begin
                n_left_key = i_rd_key;
                n_has_r    = (w_right < w_count_x);
                w_ram.rd_en   = (w_right < w_count_x);
                w_ram.rd_addr = w_right[ADDR_W-1:0];
            end
            S_DN_CMP: begin
                // The larger child moves up; the left child wins a tie.
                w_ram.wr_en   = 1'b1;
                w_ram.wr_addr = r_pos;
                if (w_right_win) begin
                    w_ram.wr_data = i_rd_key;
                    n_pos         = w_right[ADDR_W-1:0];
                end else if (w_left_gt) begin
                    w_ram.wr_data = r_left_key;
                    n_pos         = w_left[ADDR_W-1:0];
                end else begin
                    w_ram.wr_data = r_key;
                end
            end
            S_FINISH: begin
                n_status = r_status;
            end
            default: begin
                n_status = r_status;
            end
        endcase
        // Keep a copy of the root so the maximum needs no extra read.
        n_top = (w_ram.wr_en && w_ram.wr_addr == '0) ? w_ram.wr_data : r_top;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_top      <= n_top;
        r_key      <= n_key;
        r_left_key <= n_left_key;
        r_popped   <= n_popped;
        r_pos      <= n_pos;
        r_has_r    <= n_has_r;
        r_status   <= n_status;
    end

    // Handshakes and result.
    assign o_in_stall         = (r_state != S_IDLE);
    assign o_ram              = w_ram;
    assign o_res_valid        = (r_state == S_FINISH);
    assign o_res.top_value    = (r_count != '0) ? r_top : '0;
    assign o_res.popped_value = r_popped;
    assign o_res.entry_count  = r_count;
    assign o_res.status       = r_status;

    // Assertions.
    `MHPQ_ASSERT_ALWAYS(a_reset_idle, (!i_rst_n) |=> (r_state == S_IDLE && r_count == '0), "reset left the sequencer busy or the count nonzero")
    `MHPQ_ASSERT_RST(a_count_cap, r_count <= t_count'(CAPACITY), "entry count exceeds capacity")
    `MHPQ_ASSERT_RST(a_count_hold, (r_state != S_IDLE) |=> $stable(r_count), "entry count changed during a sift")
    `MHPQ_ASSERT_RST(a_wr_in_heap, w_ram.wr_en |-> ({1'b0, w_ram.wr_addr} < r_count), "key store write beyond the last entry")
    `MHPQ_ASSERT_RST(a_err_no_pop, (o_res_valid && r_status != ST_OK) |-> (r_popped == '0), "failed item reports a popped key")

endmodule

>>> src/mhpq_out_buf.sv
// ----------------------------------------------------------------------------
// mhpq_out_buf
// One-entry output register that holds a result item while the output stalls.
// ----------------------------------------------------------------------------
module mhpq_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  mhpq_pkg::t_result i_res,
    output logic              o_res_ready,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mhpq_pkg::t_result o_res
);
    import mhpq_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;
    logic    w_ready;

    // Free when empty or when the held item leaves this cycle.
    assign w_ready = !r_valid || !i_out_stall;
    assign n_valid = w_ready ? i_res_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload loads only when a new item is taken.
    always_ff @(posedge i_clk) begin
        if (w_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_res_ready = w_ready;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule

>>> src/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed 32-bit keys held in one synchronous RAM.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   in      | input     | i_in_valid / o_in_stall| operation, value, heap_index
//   out     | output    | o_out_valid/i_out_stall| top_value, popped_value,
//           |           |                        | entry_count, status
//
// Items are taken one at a time: the input stalls until the sequencer is back in
// idle. A refused item, a no-op or a pop of the last entry goes straight to its
// result; a key that is not larger is refused after a compare. An insert climbs
// level by level, an increase reads its slot and compares before it climbs, and
// a pop reads the last entry, then descends level by level to a leaf or above one.
// The single read port of the key store sets the steps: each level up is a read,
// then a compare and write; each level down is two reads, then a compare and
// write. The longest item is a pop from a full heap.
// Reset clears the entry count, the sequencer state and the output valid flag;
// key store contents are undefined and need no clearing pass.
// The output register holds one result; the next item is accepted while it
// waits, and the sequencer holds its finished result until the register frees.
// ----------------------------------------------------------------------------
module max_heap_priority_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic signed [mhpq_pkg::KEY_W-1:0] i_value,
    input  logic [mhpq_pkg::IDX_W-1:0]        i_heap_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [mhpq_pkg::KEY_W-1:0] o_top_value,
    output logic signed [mhpq_pkg::KEY_W-1:0] o_popped_value,
    output logic [mhpq_pkg::CNT_W-1:0]        o_entry_count,
    output logic [2:0]  o_status
);
    import mhpq_pkg::*;

    t_ram_req          w_ram;
    logic [KEY_W-1:0]  w_rd_data;
    logic              w_res_valid;
    logic              w_res_ready;
    t_result           w_res;
    t_result           w_out;

    // Key store.
    mhpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram.wr_en),
        .i_wr_addr (w_ram.wr_addr),
        .i_wr_data (w_ram.wr_data),
        .i_rd_en   (w_ram.rd_en),
        .i_rd_addr (w_ram.rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Sift sequencer.
    mhpq_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_value      (i_value),
        .i_heap_index (i_heap_index),
        .o_ram        (w_ram),
        .i_rd_key     ($signed(w_rd_data)),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .i_res_ready  (w_res_ready)
    );

    // Result register.
    mhpq_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_res_ready (w_res_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (w_out)
    );

    assign o_top_value    = w_out.top_value;
    assign o_popped_value = w_out.popped_value;
    assign o_entry_count  = w_out.entry_count;
    assign o_status       = w_out.status;

endmodule

>>> tb/sv/tb_max_heap_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_heap_priority_queue
// Self-checking testbench for the max-heap priority queue. It runs a directed
// pass over the corner cases, a random mix of inserts, pops and key raises,
// and a fill to full capacity followed by a complete drain. A heap predictor
// in the testbench computes the result item for every accepted item, and each
// result item from the block is checked field by field against it. Random
// gaps on the input side and random stalls on the output side keep both
// channels busy.
// ----------------------------------------------------------------------------
module tb_max_heap_priority_queue;
    import mhpq_pkg::*;

    localparam int   CYCLE_LIMIT  = 1_200_000;
    localparam int   RANDOM_ITEMS = 550;
    localparam int   DRAIN_CYCLES = 100;
    localparam t_key KEY_MAX      = 32'sh7fff_ffff;
    localparam t_key KEY_MIN      = 32'sh8000_0000;

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_in_valid   = 1'b0;
    logic                    o_in_stall;
    logic [1:0]              i_operation  = OP_NOP;
    logic signed [KEY_W-1:0] i_value      = '0;
    logic [IDX_W-1:0]        i_heap_index = '0;
    logic                    o_out_valid;
    logic                    i_out_stall  = 1'b0;
    logic signed [KEY_W-1:0] o_top_value;
    logic signed [KEY_W-1:0] o_popped_value;
    logic [CNT_W-1:0]        o_entry_count;
    logic [2:0]              o_status;

    // Predicted heap contents and the results still owed by the block.
    t_key        heap_keys [CAPACITY];
    int unsigned heap_size = 0;
    t_result     pending_results [$];

    int error_count     = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int peak_size       = 0;
    int status_hits [5] = '{default: 0};
    int cycle_count     = 0;
    int stall_left      = 0;
    bit steady_flow     = 1'b0;

    max_heap_priority_queue u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_value        (i_value),
        .i_heap_index   (i_heap_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_top_value    (o_top_value),
        .o_popped_value (o_popped_value),
        .o_entry_count  (o_entry_count),
        .o_status       (o_status)
    );

    always #5 i_clk = ~i_clk;

    // Sift a key toward the root while it beats its parent strictly.
    function automatic void heap_raise(int unsigned slot);
        int unsigned parent;
        t_key        held;
        while (slot > 0) begin
            parent = (slot - 1) / 2;
            if (heap_keys[slot] <= heap_keys[parent]) break;
            held              = heap_keys[slot];
            heap_keys[slot]   = heap_keys[parent];
            heap_keys[parent] = held;
            slot              = parent;
        end
    endfunction

    // Apply one item to the predicted heap and return the result it causes.
    function automatic t_result heap_apply(t_op op, t_key val, int unsigned slot);
        t_result     res;
        int unsigned node;
        int unsigned left;
        int unsigned right;
        int unsigned pick;
        t_key        held;
        res.popped_value = '0;
        res.status       = ST_OK;
        case (op)
            OP_INSERT: begin
                if (heap_size >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    heap_keys[heap_size] = val;
                    heap_size++;
                    heap_raise(heap_size - 1);
                end
            end
            OP_POP: begin
                if (heap_size == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.popped_value = heap_keys[0];
                    heap_size--;
                    heap_keys[0] = heap_keys[heap_size];
                    node = 0;
                    // On a tie between the children the left one is taken.
                    forever begin
                        left  = 2 * node + 1;
                        right = 2 * node + 2;
                        pick  = node;
                        if (left < heap_size && heap_keys[left] > heap_keys[pick]) pick = left;
                        if (right < heap_size && heap_keys[right] > heap_keys[pick]) pick = right;
                        if (pick == node) break;
                        held            = heap_keys[node];
                        heap_keys[node] = heap_keys[pick];
                        heap_keys[pick] = held;
                        node            = pick;
                    end
                end
            end
            OP_INCREASE: begin
                if (slot >= heap_size) begin
                    res.status = ST_BAD_INDEX;
                end else if (val <= heap_keys[slot]) begin
                    res.status = ST_NOT_LARGER;
                end else begin
                    heap_keys[slot] = val;
                    heap_raise(slot);
                end
            end
            default: ;
        endcase
        res.top_value   = (heap_size > 0) ? heap_keys[0] : '0;
        res.entry_count = heap_size[CNT_W-1:0];
        return res;
    endfunction

    // Gap or stall length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (steady_flow || roll < 60) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Keys from the full range, a narrow band that forces ties, and the edges.
    function automatic t_key random_key();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40) return t_key'($urandom);
        if (roll < 80) return t_key'($signed($urandom_range(16)) - 8);
        case ($urandom_range(5))
            0:       return KEY_MAX;
            1:       return KEY_MIN;
            2:       return KEY_MAX - 1;
            3:       return KEY_MIN + 1;
            4:       return '0;
            default: return -32'sd1;
        endcase
    endfunction

    // A key above the given one, or the same key when it is already the largest.
    function automatic t_key larger_key(t_key cur);
        longint room;
        longint step;
        room = longint'(KEY_MAX) - longint'(cur);
        if (room == 0) return cur;
        if ($urandom_range(1) == 0 || room < 1000)
            step = 1 + $urandom_range((room < 1000) ? int'(room - 1) : 999);
        else
            step = 1 + (longint'({$urandom, $urandom} & 64'h7fff_ffff_ffff_ffff) % room);
        return t_key'(longint'(cur) + step);
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Offer one item, wait for its handshake and record the expected result.
    task automatic send_item(t_op op, t_key val, logic [IDX_W-1:0] slot);
        int      gap;
        t_result res;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_value      <= val;
        i_heap_index <= slot;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        res = heap_apply(op, val, slot);
        pending_results.push_back(res);
        status_hits[res.status]++;
        items_sent++;
        if (heap_size > peak_size) peak_size = heap_size;
    endtask

    // Hold the input idle until every owed result item has come back.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Corner cases on a small heap: empty and bad-index flags, key extremes,
    // ties, raises that are not larger, and a drain past empty.
    task automatic test_directed();
        int unsigned low_slot;
        int unsigned five_slot;
        send_item(OP_POP, '0, '0);
        send_item(OP_NOP, KEY_MAX, '1);
        send_item(OP_INCREASE, 32'sd1, '0);
        send_item(OP_INSERT, KEY_MAX, '0);
        send_item(OP_INSERT, KEY_MIN, '1);
        send_item(OP_INSERT, '0, '0);
        send_item(OP_INSERT, -32'sd1, '0);
        send_item(OP_INSERT, 32'sd5, '0);
        send_item(OP_INSERT, 32'sd5, '0);
        send_item(OP_INSERT, 32'sd5, '0);
        // Equal and smaller keys are refused.
        send_item(OP_INCREASE, heap_keys[1], IDX_W'(1));
        send_item(OP_INCREASE, KEY_MIN, '0);
        // Slots at and far past the count are out of range.
        send_item(OP_INCREASE, KEY_MAX, heap_size[IDX_W-1:0]);
        send_item(OP_INCREASE, KEY_MAX, '1);
        low_slot  = 0;
        five_slot = 0;
        for (int unsigned k = 0; k < heap_size; k++) begin
            if (heap_keys[k] < heap_keys[low_slot]) low_slot = k;
            if (heap_keys[k] == 32'sd5 && five_slot == 0) five_slot = k;
        end
        // The smallest key climbs to a tie with the root and stops below it.
        send_item(OP_INCREASE, KEY_MAX, low_slot[IDX_W-1:0]);
        send_item(OP_INCREASE, 32'sd6, five_slot[IDX_W-1:0]);
        send_item(OP_NOP, '0, '0);
        while (heap_size > 0) send_item(OP_POP, random_key(), IDX_W'($urandom));
        send_item(OP_POP, KEY_MIN, '0);
    endtask

    // Mostly well-formed traffic with random content, plus refused and odd items.
    task automatic test_random_mix();
        int          roll;
        int unsigned slot;
        t_key        key;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady_flow = (n % 100) >= 70;
            roll        = $urandom_range(99);
            if (roll < 42 || (roll < 88 && heap_size == 0)) begin
                send_item(OP_INSERT, random_key(), IDX_W'($urandom));
            end else if (roll < 70) begin
                send_item(OP_POP, random_key(), IDX_W'($urandom));
            end else if (roll < 88) begin
                slot = $urandom_range(heap_size - 1);
                send_item(OP_INCREASE, larger_key(heap_keys[slot]), slot[IDX_W-1:0]);
            end else begin
                case ($urandom_range(3))
                    0: begin
                        slot = $urandom_range(CAPACITY - 1, heap_size);
                        send_item(OP_INCREASE, random_key(), slot[IDX_W-1:0]);
                    end
                    1: begin
                        slot = (heap_size > 0) ? $urandom_range(heap_size - 1) : 0;
                        key  = heap_keys[slot];
                        if (key > KEY_MIN + 3) key = key - t_key'($urandom_range(3));
                        if (heap_size == 0) key = random_key();
                        send_item(OP_INCREASE, key, slot[IDX_W-1:0]);
                    end
                    2: send_item(OP_NOP, t_key'($urandom), IDX_W'($urandom));
                    default: send_item(t_op'($urandom_range(3)), t_key'($urandom),
                                       IDX_W'($urandom));
                endcase
            end
        end
        steady_flow = 1'b0;
    endtask

    // Start from a quiet block, fill every slot, hit the full flag, then drain.
    task automatic test_fill_to_capacity();
        int unsigned slot;
        wait_for_results();
        while (heap_size > 0) send_item(OP_POP, '0, '0);
        while (heap_size < CAPACITY) send_item(OP_INSERT, random_key(), IDX_W'($urandom));
        send_item(OP_INSERT, KEY_MAX, '0);
        send_item(OP_INSERT, random_key(), '1);
        send_item(OP_INCREASE, larger_key(heap_keys[CAPACITY-1]), IDX_W'(CAPACITY - 1));
        send_item(OP_INCREASE, heap_keys[CAPACITY/2], IDX_W'(CAPACITY / 2));
        while (heap_size > 0) begin
            if ($urandom_range(99) < 85) begin
                send_item(OP_POP, '0, '0);
            end else begin
                slot = $urandom_range(heap_size - 1);
                send_item(OP_INCREASE, larger_key(heap_keys[slot]), slot[IDX_W-1:0]);
            end
        end
        send_item(OP_POP, '0, '0);
    endtask

    // Output-side stalls of random length.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = pick_gap();
        end
    end

    // Check each accepted result item against the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                report_mismatch("result item with no item waiting for it");
            end else begin
                want = pending_results.pop_front();
                if (o_top_value !== want.top_value)
                    report_mismatch($sformatf("top_value got %0d want %0d",
                                              o_top_value, want.top_value));
                if (o_popped_value !== want.popped_value)
                    report_mismatch($sformatf("popped_value got %0d want %0d",
                                              o_popped_value, want.popped_value));
                if (o_entry_count !== want.entry_count)
                    report_mismatch($sformatf("entry_count got %0d want %0d",
                                              o_entry_count, want.entry_count));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_status, want.status));
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results owed",
                     cycle_count, pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_mix();
        test_fill_to_capacity();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never came", pending_results.size()));
        $display("covered %0d items and %0d results, largest heap %0d entries",
                 items_sent, results_checked, peak_size);
        $display("refusals: empty %0d, full %0d, bad index %0d, not larger %0d",
                 status_hits[ST_EMPTY], status_hits[ST_FULL],
                 status_hits[ST_BAD_INDEX], status_hits[ST_NOT_LARGER]);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
